// ===== hw/rtl/alt_pkg.sv =====
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and codes for the array list table: request codes, item
// structs for the request and response channels, sequencer states.
// ----------------------------------------------------------------------------
package alt_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_LOCATE = 2'd3
  } req_code_t;

  localparam logic [4:0] LIMIT_RESET = 5'd10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  position;
    logic [31:0] value_in;
  } req_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] value_out;
    logic        found;
    logic [3:0]  found_index;
    logic [4:0]  list_length;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_USE,
    ST_PUT,
    ST_DONE
  } seq_state_t;

endpackage

// ===== hw/rtl/alt_ram.sv =====
// ----------------------------------------------------------------------------
// alt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/array_list_table.sv =====
// ----------------------------------------------------------------------------
// array_list_table
// Ordered list of words with insert, delete, read and locate requests,
// walked one entry at a time by a small sequencer over a single RAM.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to min(list_limit, CAPACITY) words.
// Each request item returns exactly one response item: ok, the word read or
// removed, a found flag with index for locate, and the list length after the
// request. Positions are checked against the current length. The entries sit
// in one RAM with a registered read port, so every entry moved or compared
// takes a read step and then a use step. A read request reads its one entry;
// a delete or an insert walks the entries from the position to the end, and
// a locate compares entries from 0 up to the first hit or the end. A rejected
// request or a locate on an empty list goes straight to the response. The
// longest walk is a locate miss on a full list. One request is in flight at
// a time; req_stall is high whenever the sequencer is not idle. The response
// sits in an output register, so a new request is taken while the previous
// response still waits.
// The user must write the limit register through limit_we/limit_data only
// while idle; the block itself does not enforce it. A limit below the current
// length keeps the stored entries and only blocks inserts.
module array_list_table
  import alt_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  // limit register
  input  logic      limit_we,
  input  logic [4:0] limit_data,
  // request channel
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_item,
  // response channel
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_item
);

  localparam int AW = $clog2(CAPACITY);        // RAM address bits
  localparam int CW = $clog2(CAPACITY + 1);    // count / pointer bits
  localparam int LW = (CW > 5) ? CW : 5;       // compare width

  // Registers
  logic [4:0]            list_limit;
  seq_state_t            state, state_next;
  logic [1:0]            op;
  logic [3:0]            pos;
  logic [DATA_WIDTH-1:0] val;
  logic [CW-1:0]         ptr;
  logic [CW-1:0]         count;
  logic                  first;
  logic                  res_ok;
  logic [DATA_WIDTH-1:0] res_vout;
  logic                  res_found;
  logic [CW-1:0]         res_fidx;

  // RAM port
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  // Shared step unit: pointer +/- 1 and the equality compare
  logic [CW-1:0] ptr_inc, ptr_dec;
  logic          match;
  logic          more_up;    // delete/locate: another entry above ptr
  logic          more_down;  // insert: ptr-1 still above the position

  // Checks at accept
  logic          accept, out_free;
  logic [LW-1:0] count_ext, in_pos_ext;
  logic          room, pos_le, pos_lt;
  logic [63:0]   in_value64;

  assign ptr_inc   = ptr + CW'(1);
  assign ptr_dec   = ptr - CW'(1);
  assign match     = (rd_data == val);
  assign more_up   = (ptr_inc < count);
  assign more_down = (LW'(ptr_dec) > LW'(pos));

  assign accept     = req_valid && !req_stall;
  assign req_stall  = (state != ST_IDLE);
  assign out_free   = !rsp_valid || !rsp_stall;
  assign count_ext  = LW'(count);
  assign in_pos_ext = LW'(req_item.position);
  // count < min(limit, CAPACITY)
  assign room       = (count_ext < LW'(list_limit)) && (count_ext < LW'(CAPACITY));
  assign pos_le     = (in_pos_ext <= count_ext);
  assign pos_lt     = (in_pos_ext < count_ext);
  assign in_value64 = 64'(req_item.value_in);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_item.req_type)
            REQ_INSERT: begin
              if (!(room && pos_le)) state_next = ST_DONE;
              else if (pos_lt)       state_next = ST_READ;
              else                   state_next = ST_PUT;
            end
            REQ_DELETE, REQ_READ: state_next = pos_lt ? ST_READ : ST_DONE;
            REQ_LOCATE:           state_next = (count != '0) ? ST_READ : ST_DONE;
            default:              state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: state_next = ST_USE;
      ST_USE: begin
        unique case (op)
          REQ_INSERT: state_next = more_down ? ST_READ : ST_PUT;
          REQ_DELETE: state_next = more_up ? ST_READ : ST_DONE;
          REQ_LOCATE: state_next = (!match && more_up) ? ST_READ : ST_DONE;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_PUT:  state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    rd_en   = (state == ST_READ);
    rd_addr = (op == REQ_INSERT) ? ptr_dec[AW-1:0] : ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      ST_USE: begin
        if (op == REQ_INSERT) begin
          // move entry ptr-1 up into ptr
          wr_en   = 1'b1;
          wr_addr = ptr[AW-1:0];
        end else if (op == REQ_DELETE && !first) begin
          // move entry ptr down into ptr-1
          wr_en   = 1'b1;
          wr_addr = ptr_dec[AW-1:0];
        end
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos);
        wr_data = val;
      end
      default: ;
    endcase
  end

  alt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      list_limit <= LIMIT_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (limit_we) begin
        list_limit <= limit_data;
      end
      if (state == ST_USE && op == REQ_DELETE && !more_up) begin
        count <= count - CW'(1);
      end else if (state == ST_PUT) begin
        count <= count + CW'(1);
      end
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  logic [63:0] vout64;
  logic [15:0] fidx16, count16;

  assign vout64  = 64'(res_vout);
  assign fidx16  = 16'(res_fidx);
  assign count16 = 16'(count);

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op        <= req_item.req_type;
          pos       <= req_item.position;
          val       <= DATA_WIDTH'(in_value64);
          first     <= 1'b1;
          // insert walks down from the end, locate scans up from entry 0
          ptr       <= (req_item.req_type == REQ_INSERT) ? count :
                       (req_item.req_type == REQ_LOCATE) ? '0 :
                       CW'(req_item.position);
          res_ok    <= (req_item.req_type == REQ_LOCATE);
          res_vout  <= '0;
          res_found <= 1'b0;
          res_fidx  <= '0;
        end
      end
      ST_USE: begin
        first <= 1'b0;
        unique case (op)
          REQ_INSERT: ptr <= ptr_dec;
          REQ_DELETE: begin
            if (first) res_vout <= rd_data;
            ptr <= ptr_inc;
            if (!more_up) res_ok <= 1'b1;
          end
          REQ_READ: begin
            res_vout <= rd_data;
            res_ok   <= 1'b1;
          end
          REQ_LOCATE: begin
            if (match) begin
              res_found <= 1'b1;
              res_fidx  <= ptr;
            end else begin
              ptr <= ptr_inc;
            end
          end
          default: ;
        endcase
      end
      ST_PUT:  res_ok <= 1'b1;
      ST_DONE: begin
        if (out_free) begin
          rsp_item.ok          <= res_ok;
          rsp_item.value_out   <= vout64[31:0];
          rsp_item.found       <= res_found;
          rsp_item.found_index <= fidx16[3:0];
          // count has already settled: last update happened before DONE
          rsp_item.list_length <= count16[4:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/array_list_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_list_table_test
// Self-checking bench for the array list table. A shadow copy of the list
// predicts every response from the requests taken by the block. Directed
// requests cover the edges, and random phases under several limits follow.
// ----------------------------------------------------------------------------
import alt_pkg::*;

// Shadow of the list contents plus the queue of predicted responses.
class list_shadow;
  localparam int SLOTS = 16;

  logic [31:0] slots [SLOTS];
  int unsigned used;
  logic [4:0]  limit;
  rsp_item_t   pending_rsp [$];
  int unsigned errors;

  function new();
    foreach (slots[i]) slots[i] = '0;
    used   = 0;
    limit  = LIMIT_RESET;
    errors = 0;
  endfunction

  function void set_limit(logic [4:0] v);
    limit = v;
  endfunction

  function int unsigned limit_in_use();
    return (limit > SLOTS) ? SLOTS : limit;
  endfunction

  // Update the shadow list for a taken request and queue its response.
  function void take_request(req_item_t r);
    rsp_item_t   want;
    int unsigned p;
    want = '0;
    p    = r.position;
    case (req_code_t'(r.req_type))
      REQ_INSERT: begin
        if (p <= used && used < limit_in_use()) begin
          for (int i = used; i > p; i--) slots[i] = slots[i-1];
          slots[p] = r.value_in;
          used++;
          want.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (p < used) begin
          want.value_out = slots[p];
          for (int i = p; i + 1 < used; i++) slots[i] = slots[i+1];
          slots[used-1] = '0;
          used--;
          want.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (p < used) begin
          want.value_out = slots[p];
          want.ok        = 1'b1;
        end
      end
      default: begin
        want.ok = 1'b1;
        for (int i = 0; i < used; i++) begin
          if (slots[i] == r.value_in) begin
            want.found       = 1'b1;
            want.found_index = 4'(i);
            break;
          end
        end
      end
    endcase
    want.list_length = 5'(used);
    pending_rsp.push_back(want);
  endfunction

  function void check_response(rsp_item_t got);
    rsp_item_t want;
    if (pending_rsp.size() == 0) begin
      $error("response item with no request outstanding");
      errors++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.ok !== want.ok) begin
      $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
      errors++;
    end
    if (got.value_out !== want.value_out) begin
      $error("value_out mismatch: expected %h, got %h", want.value_out, got.value_out);
      errors++;
    end
    if (got.found !== want.found) begin
      $error("found mismatch: expected %0d, got %0d", want.found, got.found);
      errors++;
    end
    if (got.found_index !== want.found_index) begin
      $error("found_index mismatch: expected %0d, got %0d",
             want.found_index, got.found_index);
      errors++;
    end
    if (got.list_length !== want.list_length) begin
      $error("list_length mismatch: expected %0d, got %0d",
             want.list_length, got.list_length);
      errors++;
    end
  endfunction
endclass

module array_list_table_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 120;
  localparam int LONG_HOLD    = 300;
  // Settle time after the last response: longer than the worst-case walk.
  localparam int TAIL_CYCLES  = 40;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       limit_we   = 1'b0;
  logic [4:0] limit_data = '0;
  logic       req_valid  = 1'b0;
  logic       req_stall;
  req_item_t  req_item   = '0;
  logic       rsp_valid;
  logic       rsp_stall  = 1'b0;
  rsp_item_t  rsp_item;

  // Percent chance of starting an idle burst after each item / each cycle.
  int unsigned req_gap_pct   = 0;
  int unsigned rsp_stall_pct = 0;
  // Raised by the main flow to ask the response side for one long hold-off.
  bit          hold_off_now  = 1'b0;
  int unsigned cycle_count   = 0;

  list_shadow sb = new();

  array_list_table #(
    .CAPACITY  (16),
    .DATA_WIDTH(32)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .limit_we  (limit_we),
    .limit_data(limit_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Response side: check every taken response item, then pick next cycle's
  // stall. Stall comes in bursts, or one long hold-off when
  // requested so the block backs up and stalls its request channel.
  initial begin
    int unsigned burst_left;
    int unsigned hold_left;
    burst_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp_item);
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (hold_off_now) begin
        hold_off_now = 1'b0;
        hold_left    = LONG_HOLD - 1;
        rsp_stall   <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        rsp_stall <= 1'b1;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
        burst_left = $urandom_range(1, 14) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic req_item_t make_req(req_code_t code, int unsigned pos,
                                         logic [31:0] val);
    req_item_t r;
    r.req_type = code;
    r.position = 4'(pos);
    r.value_in = val;
    return r;
  endfunction

  // Random request biased toward in-range positions and values already in
  // the list, so shifts and locate hits happen often. About a fifth of the
  // positions are fully random to hit the reject paths.
  function automatic req_item_t random_request();
    req_item_t   r;
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    if (sb.used >= sb.limit_in_use())
      r.req_type = (roll < 10) ? REQ_INSERT : (roll < 55) ? REQ_DELETE :
                   (roll < 75) ? REQ_READ : REQ_LOCATE;
    else
      r.req_type = (roll < 40) ? REQ_INSERT : (roll < 60) ? REQ_DELETE :
                   (roll < 80) ? REQ_READ : REQ_LOCATE;
    top = (sb.used > 15) ? 15 : sb.used;
    if ($urandom_range(0, 4) == 0 || (sb.used == 0 && r.req_type != REQ_INSERT))
      r.position = 4'($urandom_range(0, 15));
    else if (r.req_type == REQ_INSERT)
      r.position = 4'($urandom_range(0, top));
    else
      r.position = 4'($urandom_range(0, sb.used - 1));
    case ($urandom_range(0, 9))
      0, 1, 2: r.value_in = $urandom;
      3, 4:    r.value_in = $urandom_range(0, 3);
      5:       r.value_in = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: r.value_in = (sb.used != 0) ? sb.slots[$urandom_range(0, sb.used - 1)]
                                           : $urandom;
    endcase
    return r;
  endfunction

  // Offer one item and hold it until taken; maybe idle afterwards.
  task automatic send_request(req_item_t r);
    req_item  <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.take_request(r);
    if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every predicted response to come back.
  task automatic drain_responses();
    req_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Limit write; only called with the block idle.
  task automatic write_limit(logic [4:0] v);
    limit_we   <= 1'b1;
    limit_data <= v;
    @(posedge clk);
    limit_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Limits per random phase: capacity, below the count, zero, above the
  // capacity (capped), and a few in between.
  logic [4:0] phase_limit [10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4,
                                   5'd17, 5'd12, 5'd2, 5'd16, 5'd8};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the reset limit of 10.
    req_gap_pct   = 20;
    rsp_stall_pct = 20;
    send_request(make_req(REQ_READ,   0, 32'h0));          // empty list
    send_request(make_req(REQ_DELETE, 0, 32'h0));
    send_request(make_req(REQ_LOCATE, 0, 32'h0));
    send_request(make_req(REQ_INSERT, 1, 32'hCAFE_0001));  // past the end
    send_request(make_req(REQ_INSERT, 0, 32'hFFFF_FFFF));
    send_request(make_req(REQ_INSERT, 1, 32'h0000_0000));  // append
    send_request(make_req(REQ_INSERT, 0, 32'h1234_5678));  // shift all up
    send_request(make_req(REQ_INSERT, 2, 32'hA5A5_A5A5));  // middle
    send_request(make_req(REQ_LOCATE, 0, 32'h0000_0000));  // hit at the end
    send_request(make_req(REQ_LOCATE, 0, 32'hDEAD_BEEF));  // miss
    send_request(make_req(REQ_READ,  15, 32'h0));          // out of range
    send_request(make_req(REQ_READ,   3, 32'h0));
    send_request(make_req(REQ_DELETE, 1, 32'h0));          // middle
    send_request(make_req(REQ_DELETE, 2, 32'h0));          // last entry
    send_request(make_req(REQ_READ,   2, 32'h0));          // vacated slot
    // Fill up to the limit with duplicates mixed in, then overflow.
    for (int k = 0; k < 8; k++)
      send_request(make_req(REQ_INSERT, 2 + k, k[0] ? 32'h5A5A_5A5A : 32'h0000_FFFF + k));
    send_request(make_req(REQ_INSERT, 10, 32'h7777_7777)); // list full
    send_request(make_req(REQ_LOCATE, 0, 32'h5A5A_5A5A));  // first of dups
    drain_responses();

    // Limit below the count: entries stay, inserts bounce.
    write_limit(5'd3);
    send_request(make_req(REQ_INSERT, 0, 32'h1111_1111));
    send_request(make_req(REQ_DELETE, 9, 32'h0));
    send_request(make_req(REQ_READ,   0, 32'h0));
    drain_responses();

    // Random phases, one limit each; idling varies so some stretches run
    // back to back and the last phase has none.
    for (int ph = 0; ph < 10; ph++) begin
      write_limit(phase_limit[ph]);
      case (ph % 3)
        0:       begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin req_gap_pct = 30; rsp_stall_pct = 30; end
        default: begin req_gap_pct = 10; rsp_stall_pct = 50; end
      endcase
      if (ph == 9) begin
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
      end
      if (ph == 3) hold_off_now = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-phase pause with the list still populated.
        if (ph == 5 && n == PHASE_ITEMS / 2) drain_responses();
        send_request(random_request());
      end
      drain_responses();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
